// ----- sv/matrix4_vector_transform_macros.svh -----
// Assertion macros for the matrix4_vector_transform block.
// Depends on nothing; included by the top level only.
`ifndef MATRIX4_VECTOR_TRANSFORM_MACROS_SVH
`define MATRIX4_VECTOR_TRANSFORM_MACROS_SVH
`ifndef SYNTHESIS
`define M4VT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define M4VT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define M4VT_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define M4VT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- sv/m4vt_pkg.sv -----
// Shared types, constants and codes of the 4x4 matrix vector transform.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package m4vt_pkg;
   localparam int ELEM_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int DIM            = 4;
   localparam int CELLS          = DIM * DIM;
   localparam int INDEX_WIDTH    = $clog2(CELLS);
   localparam int VEC_WIDTH      = 32;

   localparam logic FUNC_LOAD      = 1'b0;
   localparam logic FUNC_TRANSFORM = 1'b1;

   typedef struct packed {
      logic                        func;
      logic [INDEX_WIDTH-1:0]      elem_index;
      logic signed [VEC_WIDTH-1:0] elem_value;
      logic signed [VEC_WIDTH-1:0] vec_x;
      logic signed [VEC_WIDTH-1:0] vec_y;
      logic signed [VEC_WIDTH-1:0] vec_z;
      logic signed [VEC_WIDTH-1:0] vec_w;
   } req_type;

   typedef struct packed {
      logic signed [VEC_WIDTH-1:0] out_x;
      logic signed [VEC_WIDTH-1:0] out_y;
      logic signed [VEC_WIDTH-1:0] out_z;
      logic signed [VEC_WIDTH-1:0] out_w;
      logic                        saturated;
   } rsp_type;

   typedef struct packed {
      logic en1;
      logic en2;
      logic en3;
   } adv_type;

   typedef struct packed {
      logic valid3;
      logic rsp_ready;
   } merge_ctrl_type;
endpackage
`default_nettype wire

// ----- sv/m4vt_matrix_store.sv -----
// Matrix element registers, column-major, reset to identity.
// Depends on m4vt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module m4vt_matrix_store #(
   parameter int ELEM_WIDTH = m4vt_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = m4vt_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 wr_en,
   input  wire logic [m4vt_pkg::INDEX_WIDTH-1:0]     wr_index,
   input  wire logic signed [m4vt_pkg::VEC_WIDTH-1:0] wr_value,
   output logic signed [ELEM_WIDTH-1:0]              elem [m4vt_pkg::CELLS]
);
   localparam logic [ELEM_WIDTH-1:0] ONE = ELEM_WIDTH'(64'd1 << FRAC_BITS);

   logic signed [ELEM_WIDTH-1:0] elem_ff [m4vt_pkg::CELLS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < m4vt_pkg::CELLS; i++) begin
            elem_ff[i] <= ((i % m4vt_pkg::DIM) == (i / m4vt_pkg::DIM)) ? ONE : '0;
         end
      end else if (wr_en) begin
         elem_ff[wr_index] <= wr_value[ELEM_WIDTH-1:0];
      end
   end

   assign elem = elem_ff;
endmodule
`default_nettype wire

// ----- sv/m4vt_lane.sv -----
// One output row: four multipliers, a two-level adder tree, shift and saturate.
// Depends on m4vt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module m4vt_lane #(
   parameter int ELEM_WIDTH = m4vt_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = m4vt_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire m4vt_pkg::adv_type                     adv,
   input  wire logic signed [ELEM_WIDTH-1:0]          col_elem [m4vt_pkg::DIM],
   input  wire logic signed [m4vt_pkg::VEC_WIDTH-1:0] vec [m4vt_pkg::DIM],
   output logic signed [ELEM_WIDTH-1:0]               res,
   output logic                                       clip
);
   localparam int PW  = ELEM_WIDTH + m4vt_pkg::VEC_WIDTH;
   localparam int SW  = PW + 2;
   localparam int UPW = SW - ELEM_WIDTH + 1;

   logic signed [PW-1:0]   prod_ff [m4vt_pkg::DIM];
   logic signed [PW-1:0]   prod_in [m4vt_pkg::DIM];
   logic signed [PW:0]     pair_ff [2];
   logic signed [PW:0]     pair_in [2];
   logic signed [SW-1:0]   sum_ff;
   logic signed [SW-1:0]   sum_in;
   logic signed [SW-1:0]   shifted;
   logic [UPW-1:0]         upper;

   always_comb begin
      for (int c = 0; c < m4vt_pkg::DIM; c++) begin
         prod_in[c] = PW'(col_elem[c]) * PW'(vec[c]);
      end
      pair_in[0] = (PW+1)'(prod_ff[0]) + (PW+1)'(prod_ff[1]);
      pair_in[1] = (PW+1)'(prod_ff[2]) + (PW+1)'(prod_ff[3]);
      sum_in     = SW'(pair_ff[0]) + SW'(pair_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (adv.en1) begin
         prod_ff <= prod_in;
      end
      if (adv.en2) begin
         pair_ff <= pair_in;
      end
      if (adv.en3) begin
         sum_ff <= sum_in;
      end
   end

   always_comb begin
      shifted = sum_ff >>> FRAC_BITS;
      upper   = shifted[SW-1:ELEM_WIDTH-1];
      clip    = (upper != '0) && (upper != '1);
      if (!clip) begin
         res = shifted[ELEM_WIDTH-1:0];
      end else if (shifted[SW-1]) begin
         res = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
      end else begin
         res = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
      end
   end
endmodule
`default_nettype wire

// ----- sv/m4vt_merge.sv -----
// Output register: gathers the four lane results and the clipping flag.
// Depends on m4vt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module m4vt_merge #(
   parameter int ELEM_WIDTH = m4vt_pkg::ELEM_WIDTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire m4vt_pkg::merge_ctrl_type     ctrl,
   input  wire logic signed [ELEM_WIDTH-1:0] lane_res [m4vt_pkg::DIM],
   input  wire logic [m4vt_pkg::DIM-1:0]     lane_clip,
   output logic                              out_free,
   output logic                              rsp_valid,
   output m4vt_pkg::rsp_type                 rsp_data
);
   localparam int VW = m4vt_pkg::VEC_WIDTH;

   logic              rsp_valid_ff;
   m4vt_pkg::rsp_type rsp_ff;
   m4vt_pkg::rsp_type rsp_in;

   assign out_free = !rsp_valid_ff || ctrl.rsp_ready;

   always_comb begin
      rsp_in.out_x     = VW'(lane_res[0]);
      rsp_in.out_y     = VW'(lane_res[1]);
      rsp_in.out_z     = VW'(lane_res[2]);
      rsp_in.out_w     = VW'(lane_res[3]);
      rsp_in.saturated = |lane_clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= ctrl.valid3;
      end
      if (out_free) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

// ----- sv/matrix4_vector_transform.sv -----
// 4x4 matrix times vector, Q16.16. A transform item passes the product,
// pair-sum and sum registers and then the output register. One item is
// accepted per cycle while the output is not stalled; four row lanes of four
// multipliers each feed a registered adder tree. Load items give no result.
// Reset (synchronous) empties the pipeline and sets the matrix to identity at once.
`timescale 1ns / 1ps
`default_nettype none
`include "matrix4_vector_transform_macros.svh"
module matrix4_vector_transform #(
   parameter int ELEM_WIDTH = m4vt_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = m4vt_pkg::FRAC_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire m4vt_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output m4vt_pkg::rsp_type      rsp_data
);
   localparam int DIM = m4vt_pkg::DIM;

   logic signed [ELEM_WIDTH-1:0]          elem [m4vt_pkg::CELLS];
   logic signed [m4vt_pkg::VEC_WIDTH-1:0] vec [DIM];
   logic signed [ELEM_WIDTH-1:0]          col_elem [DIM][DIM];
   logic signed [ELEM_WIDTH-1:0]          lane_res [DIM];
   logic [DIM-1:0]                        lane_clip;
   logic                                  valid1_ff, valid2_ff, valid3_ff;
   logic                                  out_free;
   logic                                  accept;
   logic                                  load_en;
   m4vt_pkg::adv_type                     adv;
   m4vt_pkg::merge_ctrl_type              mctrl;

   always_comb begin
      adv.en3   = !valid3_ff || out_free;
      adv.en2   = !valid2_ff || adv.en3;
      adv.en1   = !valid1_ff || adv.en2;
      req_ready = adv.en1;
      accept    = req_valid && req_ready;
      load_en   = accept && (req_data.func == m4vt_pkg::FUNC_LOAD);
      mctrl.valid3    = valid3_ff;
      mctrl.rsp_ready = rsp_ready;
      vec[0] = req_data.vec_x;
      vec[1] = req_data.vec_y;
      vec[2] = req_data.vec_z;
      vec[3] = req_data.vec_w;
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            col_elem[r][c] = elem[c * DIM + r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         if (adv.en1) begin
            valid1_ff <= req_valid && (req_data.func == m4vt_pkg::FUNC_TRANSFORM);
         end
         if (adv.en2) begin
            valid2_ff <= valid1_ff;
         end
         if (adv.en3) begin
            valid3_ff <= valid2_ff;
         end
      end
   end

   m4vt_matrix_store #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (load_en),
      .wr_index (req_data.elem_index),
      .wr_value (req_data.elem_value),
      .elem     (elem)
   );

   for (genvar r = 0; r < DIM; r++) begin : g_lane
      m4vt_lane #(
         .ELEM_WIDTH (ELEM_WIDTH),
         .FRAC_BITS  (FRAC_BITS)
      ) u_lane (
         .clock    (clock),
         .adv      (adv),
         .col_elem (col_elem[r]),
         .vec      (vec),
         .res      (lane_res[r]),
         .clip     (lane_clip[r])
      );
   end

   m4vt_merge #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (mctrl),
      .lane_res  (lane_res),
      .lane_clip (lane_clip),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `M4VT_ASSERT_NEXT(a_load_no_result, clock, reset, load_en, !valid1_ff, "load item entered pipeline")
   `M4VT_ASSERT_NEXT(a_xform_enters, clock, reset, accept && !load_en, valid1_ff, "transform item lost")
   `M4VT_ASSERT_NEXT(a_result_moves, clock, reset, valid3_ff && !rsp_valid, rsp_valid, "result not moved out")
   `M4VT_ASSERT_NOW(a_stall_ready, clock, reset, valid1_ff && valid2_ff && valid3_ff && rsp_valid && !rsp_ready, !req_ready, "item taken into full pipeline")
endmodule
`default_nettype wire

// ----- test/tb_matrix4_vector_transform.sv -----
// Self-checking testbench for the 4x4 Q16.16 matrix vector transform.
// Depends on m4vt_pkg and the matrix4_vector_transform top level only.
// A checker class keeps its own matrix copy and the queue of expected vectors.
`timescale 1ns / 1ps
module tb_matrix4_vector_transform;
   localparam int FRAC       = m4vt_pkg::FRAC_BITS_DEF;
   localparam int CELLS      = m4vt_pkg::CELLS;
   localparam int DIM        = m4vt_pkg::DIM;
   localparam int REQ_BITS   = $bits(m4vt_pkg::req_type);
   localparam int QUIET_MAX  = 4000;
   localparam int ITEMS_EACH = 362;
   localparam int HOLD_LEN   = 80;
   localparam logic signed [31:0] Q_MIN_32 = 32'sh8000_0000;
   localparam logic signed [31:0] Q_MAX_32 = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_ONE    = 32'sh0001_0000;
   localparam logic signed [65:0] SUM_MAX  = 66'sd2147483647;
   localparam logic signed [65:0] SUM_MIN  = -66'sd2147483648;

   class vector_transform_checker;
      logic signed [31:0] matrix_q [CELLS];
      m4vt_pkg::rsp_type expected_vectors [$];
      int mismatches;
      int loads;
      int transforms;
      int clipped;

      function new();
         for (int i = 0; i < CELLS; i++)
            matrix_q[i] = (i % (DIM + 1) == 0) ? Q_ONE : 32'sd0;
         mismatches = 0;
         loads      = 0;
         transforms = 0;
         clipped    = 0;
      endfunction

      function m4vt_pkg::rsp_type predict_transform(m4vt_pkg::req_type item);
         logic signed [31:0] vec [DIM];
         logic signed [31:0] lane [DIM];
         logic signed [65:0] m_ext;
         logic signed [65:0] v_ext;
         logic signed [65:0] acc;
         logic signed [65:0] shifted;
         m4vt_pkg::rsp_type result;
         vec[0] = item.vec_x;
         vec[1] = item.vec_y;
         vec[2] = item.vec_z;
         vec[3] = item.vec_w;
         result = '0;
         for (int r = 0; r < DIM; r++) begin
            acc = '0;
            for (int c = 0; c < DIM; c++) begin
               m_ext = matrix_q[c * DIM + r];
               v_ext = vec[c];
               acc = acc + m_ext * v_ext;
            end
            shifted = acc >>> FRAC;
            if (shifted > SUM_MAX) begin
               lane[r] = Q_MAX_32;
               result.saturated = 1'b1;
            end else if (shifted < SUM_MIN) begin
               lane[r] = Q_MIN_32;
               result.saturated = 1'b1;
            end else begin
               lane[r] = shifted[31:0];
            end
         end
         result.out_x = lane[0];
         result.out_y = lane[1];
         result.out_z = lane[2];
         result.out_w = lane[3];
         return result;
      endfunction

      function void accept_item(m4vt_pkg::req_type item);
         m4vt_pkg::rsp_type exp_vec;
         if (item.func == m4vt_pkg::FUNC_LOAD) begin
            matrix_q[item.elem_index] = item.elem_value;
            loads++;
         end else begin
            exp_vec = predict_transform(item);
            expected_vectors.push_back(exp_vec);
            transforms++;
            if (exp_vec.saturated)
               clipped++;
         end
      endfunction

      function void check_vector(m4vt_pkg::rsp_type got);
         m4vt_pkg::rsp_type exp_vec;
         if (expected_vectors.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %h with nothing outstanding", got);
            return;
         end
         exp_vec = expected_vectors.pop_front();
         if (got.out_x !== exp_vec.out_x || got.out_y !== exp_vec.out_y ||
             got.out_z !== exp_vec.out_z || got.out_w !== exp_vec.out_w ||
             got.saturated !== exp_vec.saturated) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp x=%h y=%h z=%h w=%h s=%b, got x=%h y=%h z=%h w=%h s=%b",
                        exp_vec.out_x, exp_vec.out_y, exp_vec.out_z, exp_vec.out_w,
                        exp_vec.saturated, got.out_x, got.out_y, got.out_z, got.out_w,
                        got.saturated);
         end
      endfunction

      function int pending();
         return expected_vectors.size();
      endfunction
   endclass

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   m4vt_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   m4vt_pkg::rsp_type rsp_data;

   vector_transform_checker sb;
   int idle_pct     = 0;
   int stall_pct    = 0;
   bit hold_request = 1'b0;
   int quiet_cycles = 0;
   int idle_tab [4]  = '{0, 70, 0, 17};
   int stall_tab [4] = '{0, 0, 70, 17};

   matrix4_vector_transform u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.accept_item(req_data);
         if (rsp_valid && rsp_ready)
            sb.check_vector(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_MAX) begin
            $display("timeout after %0d cycles without a handshake", QUIET_MAX);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   function automatic logic signed [31:0] rand_q();
      case ($urandom_range(9))
         0: return Q_MIN_32;
         1: return Q_MAX_32;
         2: return 32'sd0;
         3: return Q_ONE;
         4: return -Q_ONE;
         5, 6: return 32'(int'($urandom_range(4194303)) - 2097152);
         default: return $urandom;
      endcase
   endfunction

   function automatic m4vt_pkg::req_type make_load(int idx, logic signed [31:0] value);
      m4vt_pkg::req_type item;
      item = REQ_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      item.func       = m4vt_pkg::FUNC_LOAD;
      item.elem_index = idx[m4vt_pkg::INDEX_WIDTH-1:0];
      item.elem_value = value;
      return item;
   endfunction

   function automatic m4vt_pkg::req_type make_transform(
      logic signed [31:0] x, logic signed [31:0] y,
      logic signed [31:0] z, logic signed [31:0] w);
      m4vt_pkg::req_type item;
      item = REQ_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      item.func  = m4vt_pkg::FUNC_TRANSFORM;
      item.vec_x = x;
      item.vec_y = y;
      item.vec_z = z;
      item.vec_w = w;
      return item;
   endfunction

   function automatic m4vt_pkg::req_type make_random_item();
      if ($urandom_range(99) < 25)
         return make_load($urandom_range(CELLS - 1), rand_q());
      return make_transform(rand_q(), rand_q(), rand_q(), rand_q());
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(input m4vt_pkg::req_type item);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
   endtask

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // identity matrix after reset
      send_item(make_transform(Q_ONE, 2 * Q_ONE, 3 * Q_ONE, -4 * Q_ONE));
      send_item(make_transform(Q_MIN_32, Q_MAX_32, 32'sd0, -32'sd1));
      // fill every element with the most negative value
      for (int i = 0; i < CELLS; i++)
         send_item(make_load(i, Q_MIN_32));
      // sum of four products past 64 bits, then negative clipping
      send_item(make_transform(Q_MIN_32, Q_MIN_32, Q_MIN_32, Q_MIN_32));
      send_item(make_transform(Q_MAX_32, Q_MAX_32, Q_MAX_32, Q_MAX_32));
      send_item(make_transform(32'sd0, 32'sd0, 32'sd0, 32'sd0));
      // floor rounding of a negative product
      send_item(make_load(0, -32'sd3));
      send_item(make_transform(32'sd1, 32'sd0, 32'sd0, 32'sd0));
      send_item(make_transform(32'sd1, 32'sd1, 32'sd1, 32'sd1));
      drain_results();

      for (int p = 0; p < 4; p++) begin
         idle_pct  = idle_tab[p];
         stall_pct = stall_tab[p];
         @(negedge clock);
         for (int n = 0; n < ITEMS_EACH; n++) begin
            if (p == 0 && n == 100)
               hold_request = 1'b1;
            send_item(make_random_item());
         end
         drain_results();
      end

      repeat (8) @(negedge clock);
      $display("covered %0d element loads and %0d transforms, %0d with clipping,",
               sb.loads, sb.transforms, sb.clipped);
      $display("over four idle and stall mixes including a long output hold-off");
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

// ----- matrix4_vector_transform.f -----
+incdir+sv
sv/m4vt_pkg.sv
sv/m4vt_matrix_store.sv
sv/m4vt_lane.sv
sv/m4vt_merge.sv
sv/matrix4_vector_transform.sv
test/tb_matrix4_vector_transform.sv
